@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL; they compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");
// The antecedent in one cycle implies the consequent in the next.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_ALWAYS(lbl, clk, rstn, cond)
`define AST_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/rip_pkg.sv @@
// Types, codes and the character classifier of the radix integer parser.
`default_nettype none
package rip_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
        logic [15:0] consumed_count;
        logic [7:0]  stop_char;
        logic        stop_char_valid;
    } t_out_word;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_DIGITS = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_RADIX  = 2'd0;
    localparam logic [1:0] CFG_SIGNED = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;

    // Width codes
    localparam logic [1:0] WC_8  = 2'd0;
    localparam logic [1:0] WC_16 = 2'd1;
    localparam logic [1:0] WC_32 = 2'd2;
    localparam logic [1:0] WC_64 = 2'd3;

    localparam logic [5:0] RADIX_DEFAULT = 6'd10;
    localparam logic [5:0] RADIX_MAX     = 6'd36;
    localparam logic [6:0] DIGIT_NONE    = 7'd64;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_PLUS       = 8'h2B;

    // Worth of a character as a digit, DIGIT_NONE for anything else
    function automatic logic [6:0] digit_worth(input logic [7:0] c);
        logic [6:0] w;
        w = DIGIT_NONE;
        if (c >= 8'h30 && c <= 8'h39) begin
            w = 7'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            w = 7'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            w = 7'(c - 8'h61 + 8'd10);
        end
        return w;
    endfunction

endpackage
`default_nettype wire

@@ sv/radix_integer_parser_core.sv @@
// Radix integer parser: streams characters in, one parsed token word out per token.
//
//  Channel   Direction  Handshake                  Word
//  input     in         i_in_valid / o_in_ready    i_in_word  (char_code, end_of_text)
//  output    out        o_out_valid / i_out_ready  o_out_word (value, status, count, stop)
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
//  One character is taken every cycle unless a token end waits on a stall; the
//  loop that sets this is the 64-bit accumulator times the 6-bit radix plus digit.
//  The ending character goes from the input register to the finish and output registers.
//  Reset is synchronous, active low; no clearing pass, ready right after reset.
//  A stall on the output backs up through the three registers only as far as
//  needed; characters that do not end a token keep flowing into the parser state.
`default_nettype none
`include "assert_macros.svh"
module radix_integer_parser_core
    import rip_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [5:0] i_cfg_data,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_word      o_out_word
);

    // Token record handed from the parse stage to the finish stage
    typedef struct packed {
        logic [63:0] acc;
        logic        neg;
        logic        seen;
        logic [15:0] cnt;
        logic [7:0]  stop;
        logic        stop_v;
    } t_tok;

    // Configuration
    logic [5:0] r_radix;
    logic       r_signed;
    logic [1:0] r_width;

    // Stage 1: input register
    logic     r_in_vld;
    t_in_word r_in;

    // Parser state
    logic [63:0] r_acc;
    logic        r_neg;
    logic        r_seen;
    logic        r_start;
    logic [15:0] r_cnt;

    // Stage 2: finished token, stage 3: result word
    logic      r_fin_vld;
    t_tok      r_fin;
    logic      r_out_vld;
    t_out_word r_out;

    // Handshake chain
    logic out_take;
    logic fin_ready;
    logic proc_go;

    // Parse stage
    logic [5:0]  base;
    logic [6:0]  worth;
    logic        is_sign;
    logic        is_digit;
    logic        ends;
    logic [63:0] n_acc;
    logic [15:0] n_cnt;
    logic        n_neg;
    t_tok        n_fin;

    // Finish stage
    logic [63:0] val;
    logic        out_of_range;
    t_out_word   n_out;

    assign out_take   = !r_out_vld || i_out_ready;
    assign fin_ready  = !r_fin_vld || out_take;
    assign proc_go    = r_in_vld && (!ends || fin_ready);
    assign o_in_ready = !r_in_vld || proc_go;

    always_comb begin
        base     = (r_radix == 6'd0) ? RADIX_DEFAULT : r_radix;
        worth    = digit_worth(r_in.char_code);
        is_sign  = r_start && r_signed &&
                   (r_in.char_code == CH_MINUS || r_in.char_code == CH_PLUS);
        is_digit = (r_radix <= RADIX_MAX) && (worth < {1'b0, base});
        ends     = !(is_sign || is_digit) || r_in.end_of_text;
        // wraps mod 2^64
        n_acc    = r_acc * {58'd0, base} + {57'd0, worth};
        n_cnt    = (r_cnt == 16'hFFFF) ? r_cnt : r_cnt + 16'd1;
        n_neg    = is_sign ? (r_in.char_code == CH_MINUS) : r_neg;

        if (is_sign || is_digit) begin
            // token ends only by end of text: no stop character
            n_fin.acc    = is_digit ? n_acc : r_acc;
            n_fin.neg    = n_neg;
            n_fin.seen   = r_seen || is_digit;
            n_fin.cnt    = n_cnt;
            n_fin.stop   = 8'd0;
            n_fin.stop_v = 1'b0;
        end else begin
            // a non-digit ends the token and is reported, not counted
            n_fin.acc    = r_acc;
            n_fin.neg    = r_neg;
            n_fin.seen   = r_seen;
            n_fin.cnt    = r_cnt;
            n_fin.stop   = r_in.char_code;
            n_fin.stop_v = 1'b1;
        end
    end

    // Range check: unsigned wants the bits above the width clear, signed wants
    // the bits from the sign position up all equal; a 64-bit width always passes.
    always_comb begin
        val = r_fin.neg ? (64'd0 - r_fin.acc) : r_fin.acc;
        case (r_width)
            WC_8: begin
                out_of_range = r_signed ? !((&val[63:7]) || !(|val[63:7]))
                                        : (|val[63:8]);
            end
            WC_16: begin
                out_of_range = r_signed ? !((&val[63:15]) || !(|val[63:15]))
                                        : (|val[63:16]);
            end
            WC_32: begin
                out_of_range = r_signed ? !((&val[63:31]) || !(|val[63:31]))
                                        : (|val[63:32]);
            end
            default: begin
                out_of_range = 1'b0;
            end
        endcase

        n_out.consumed_count  = r_fin.cnt;
        n_out.stop_char       = r_fin.stop;
        n_out.stop_char_valid = r_fin.stop_v;
        if (!r_fin.seen) begin
            n_out.value  = 64'd0;
            n_out.status = ST_NO_DIGITS;
        end else begin
            n_out.value  = val;
            n_out.status = out_of_range ? ST_RANGE : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix   <= 6'd0;
            r_signed  <= 1'b0;
            r_width   <= WC_64;
            r_in_vld  <= 1'b0;
            r_acc     <= 64'd0;
            r_neg     <= 1'b0;
            r_seen    <= 1'b0;
            r_start   <= 1'b1;
            r_cnt     <= 16'd0;
            r_fin_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIX:  r_radix  <= i_cfg_data;
                    CFG_SIGNED: r_signed <= i_cfg_data[0];
                    CFG_WIDTH:  r_width  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end

            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end

            if (proc_go) begin
                if (ends) begin
                    r_acc   <= 64'd0;
                    r_neg   <= 1'b0;
                    r_seen  <= 1'b0;
                    r_start <= 1'b1;
                    r_cnt   <= 16'd0;
                end else begin
                    r_acc   <= is_digit ? n_acc : r_acc;
                    r_neg   <= n_neg;
                    r_seen  <= r_seen || is_digit;
                    r_start <= 1'b0;
                    r_cnt   <= n_cnt;
                end
            end

            if (fin_ready) begin
                r_fin_vld <= proc_go && ends;
            end

            if (out_take) begin
                r_out_vld <= r_fin_vld;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in <= i_in_word;
        end
        if (fin_ready) begin
            r_fin <= n_fin;
        end
        if (out_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // A character that keeps the token open always leaves a nonzero count.
    `AST_NEXT(a_count_grows, i_clk, i_rst_n, proc_go && !ends, r_cnt != 16'd0 && !r_start)
    // Once a token is closed the parser is back at a clean token start.
    `AST_NEXT(a_token_clear, i_clk, i_rst_n, proc_go && ends,
              r_start && r_acc == 64'd0 && r_cnt == 16'd0 && !r_seen)
    // A finished token behind a stalled result is held, not dropped.
    `AST_NEXT(a_fin_held, i_clk, i_rst_n, r_fin_vld && r_out_vld && !i_out_ready, r_fin_vld)

endmodule
`default_nettype wire
